// ===== hw/rtl/rstab_pkg.sv =====
// rstab_pkg: shared types and constants of the randomized set table
// operation and status codes, field widths, controller/datapath command and status structs
// no dependencies
package rstab_pkg;

    localparam int CAPACITY_DEF  = 16;
    localparam int DRAW_BITS_DEF = 16;

    localparam int CMD_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int SIZE_W   = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SAMPLE = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_NOCHANGE = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic    load;
        logic    scan;
        logic    append;
        logic    move_rd;
        logic    move_wr;
        logic    samp_mul;
        logic    samp_rd;
        logic    finish;
        logic    take_sample;
        status_t status;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hit;
        logic scan_done;
        logic empty;
        logic full;
    } dp_stat_t;

endpackage

// ===== hw/rtl/rstab_in_if.sv =====
// rstab_in_if: request channel of the randomized set table
// valid/ready handshake with command, value and random draw; uses rstab_pkg
interface rstab_in_if #(
    parameter int DRAW_BITS = rstab_pkg::DRAW_BITS_DEF
);
    logic                             valid;
    logic                             ready;
    logic [rstab_pkg::CMD_W-1:0]      cmd;
    logic signed [rstab_pkg::VALUE_W-1:0] value;
    logic [DRAW_BITS-1:0]             random_draw;

    modport source (
        output valid, cmd, value, random_draw,
        input  ready
    );

    modport sink (
        input  valid, cmd, value, random_draw,
        output ready
    );
endinterface

// ===== hw/rtl/rstab_out_if.sv =====
// rstab_out_if: response channel of the randomized set table
// valid/ready handshake with status, sampled value and size; uses rstab_pkg
interface rstab_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [rstab_pkg::STATUS_W-1:0]       status;
    logic signed [rstab_pkg::VALUE_W-1:0] sample_value;
    logic [rstab_pkg::SIZE_W-1:0]         size_after;

    modport source (
        output valid, status, sample_value, size_after,
        input  ready
    );

    modport sink (
        input  valid, status, sample_value, size_after,
        output ready
    );
endinterface

// ===== hw/rtl/randomized_set_table.sv =====
// randomized_set_table: top level of the randomized set table
// joins rstab_ctrl and rstab_dp to the request and response channels
// uses rstab_pkg, rstab_in_if, rstab_out_if
//
//   channel  dir  beat contents
//   req      in   cmd, value, random_draw
//   rsp      out  status, sample_value, size_after
//
// insert/remove scan until a hit or past the last entry; an insert miss appends unless full
// a remove hit moves the last entry into the hit slot; sample multiplies, then reads the entry
// the scan reads one store entry per cycle through the single read port, one comparator
// reset clears the count and handshake state; store contents need no clearing
// a new request is taken while a response waits; a stalled response holds the next one
module randomized_set_table #(
    parameter int CAPACITY  = rstab_pkg::CAPACITY_DEF,
    parameter int DRAW_BITS = rstab_pkg::DRAW_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    rstab_in_if.sink    req,
    rstab_out_if.source rsp
);

    rstab_pkg::dp_cmd_t  dp_cmd;
    rstab_pkg::dp_stat_t dp_stat;
    logic [rstab_pkg::STATUS_W-1:0] rsp_status;
    logic [rstab_pkg::VALUE_W-1:0]  rsp_sample;
    logic [rstab_pkg::VALUE_W-1:0]  req_value;
    logic [DRAW_BITS-1:0]           req_draw;

    assign req_value = req.value;
    assign req_draw  = req.random_draw;

    rstab_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_cmd   (rstab_pkg::cmd_t'(req.cmd)),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (dp_cmd),
        .stat      (dp_stat)
    );

    rstab_dp #(
        .CAPACITY  (CAPACITY),
        .DRAW_BITS (DRAW_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (dp_cmd),
        .stat       (dp_stat),
        .req_value  (req_value),
        .req_draw   (req_draw),
        .rsp_status (rsp_status),
        .rsp_sample (rsp_sample),
        .rsp_size   (rsp.size_after)
    );

    assign rsp.status       = rsp_status;
    assign rsp.sample_value = rsp_sample;

endmodule

// ===== hw/rtl/rstab_ctrl.sv =====
// rstab_ctrl: sequencer of the randomized set table
// steps each command through scan, move, sample and response; uses rstab_pkg
module rstab_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  rstab_pkg::cmd_t     req_cmd,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output rstab_pkg::dp_cmd_t  cmd,
    input  rstab_pkg::dp_stat_t stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MOVE_RD,
        S_MOVE_WR,
        S_SAMP_MUL,
        S_SAMP_RD,
        S_FINISH
    } state_t;

    state_t              state_reg, state_next;
    rstab_pkg::cmd_t     op_reg, op_next;
    rstab_pkg::status_t  status_reg, status_next;
    logic                sample_sel_reg, sample_sel_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic                slot_free;

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        status_next     = status_reg;
        sample_sel_next = sample_sel_reg;
        rsp_valid_next  = rsp_valid_reg;
        cmd             = '0;
        cmd.status      = status_reg;
        cmd.take_sample = sample_sel_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load        = 1'b1;
                    op_next         = req_cmd;
                    status_next     = rstab_pkg::ST_DONE;
                    sample_sel_next = 1'b0;
                    case (req_cmd)
                        rstab_pkg::CMD_INSERT,
                        rstab_pkg::CMD_REMOVE:
                        begin
                            state_next = S_SCAN;
                        end
                        rstab_pkg::CMD_SAMPLE:
                        begin
                            if (stat.empty)
                            begin
                                status_next = rstab_pkg::ST_EMPTY;
                                state_next  = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_SAMP_MUL;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.hit)
                begin
                    if (op_reg == rstab_pkg::CMD_REMOVE)
                    begin
                        state_next = S_MOVE_RD;
                    end
                    else
                    begin
                        status_next = rstab_pkg::ST_NOCHANGE;
                        state_next  = S_FINISH;
                    end
                end
                else if (stat.scan_done)
                begin
                    state_next = S_FINISH;
                    if (op_reg == rstab_pkg::CMD_INSERT)
                    begin
                        if (stat.full)
                        begin
                            status_next = rstab_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.append = 1'b1;
                        end
                    end
                    else
                    begin
                        status_next = rstab_pkg::ST_NOCHANGE;
                    end
                end
            end
            S_MOVE_RD:
            begin
                cmd.move_rd = 1'b1;
                state_next  = S_MOVE_WR;
            end
            S_MOVE_WR:
            begin
                cmd.move_wr = 1'b1;
                state_next  = S_FINISH;
            end
            S_SAMP_MUL:
            begin
                cmd.samp_mul = 1'b1;
                state_next   = S_SAMP_RD;
            end
            S_SAMP_RD:
            begin
                cmd.samp_rd     = 1'b1;
                sample_sel_next = 1'b1;
                state_next      = S_FINISH;
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.finish     = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= rstab_pkg::CMD_NOP;
            status_reg     <= rstab_pkg::ST_DONE;
            sample_sel_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            status_reg     <= status_next;
            sample_sel_reg <= sample_sel_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

endmodule

// ===== hw/rtl/rstab_dp.sv =====
// rstab_dp: datapath of the randomized set table
// value store, element count, scan comparator, sample index multiplier, response registers
// uses rstab_pkg
module rstab_dp #(
    parameter int CAPACITY  = rstab_pkg::CAPACITY_DEF,
    parameter int DRAW_BITS = rstab_pkg::DRAW_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rstab_pkg::dp_cmd_t                   cmd,
    output rstab_pkg::dp_stat_t                  stat,
    input  logic [rstab_pkg::VALUE_W-1:0]        req_value,
    input  logic [DRAW_BITS-1:0]                 req_draw,
    output logic [rstab_pkg::STATUS_W-1:0]       rsp_status,
    output logic [rstab_pkg::VALUE_W-1:0]        rsp_sample,
    output logic [rstab_pkg::SIZE_W-1:0]         rsp_size
);

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int PROD_W = DRAW_BITS + CNT_W;

    logic [rstab_pkg::VALUE_W-1:0] mem [CAPACITY];

    logic [rstab_pkg::VALUE_W-1:0]  value_reg;
    logic [DRAW_BITS-1:0]           draw_reg;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [CNT_W-1:0]               scan_idx_reg, scan_idx_next;
    logic                           cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]               cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]               samp_idx_reg;
    logic [rstab_pkg::VALUE_W-1:0]  rd_data_reg;
    logic [rstab_pkg::STATUS_W-1:0] status_out_reg;
    logic [rstab_pkg::VALUE_W-1:0]  sample_out_reg;
    logic [rstab_pkg::SIZE_W-1:0]   size_out_reg;

    logic                           hit;
    logic                           scan_more;
    logic                           issue;
    logic                           re;
    logic [IDX_W-1:0]               raddr;
    logic [CNT_W-1:0]               last_idx;
    logic                           we;
    logic [IDX_W-1:0]               waddr;
    logic [rstab_pkg::VALUE_W-1:0]  wdata;
    logic [PROD_W-1:0]              prod;

    assign hit       = cmp_valid_reg && (rd_data_reg == value_reg);
    assign scan_more = (scan_idx_reg < count_reg);
    assign issue     = cmd.scan && !hit && scan_more;
    assign last_idx  = count_reg - CNT_W'(1);
    assign prod      = PROD_W'(draw_reg) * PROD_W'(count_reg);

    assign stat.hit       = hit;
    assign stat.scan_done = !cmp_valid_reg && !scan_more;
    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg >= CNT_W'(CAPACITY));

    // single read port: scan, last entry for a remove, sample entry
    always_comb
    begin
        re    = issue || cmd.move_rd || cmd.samp_rd;
        raddr = scan_idx_reg[IDX_W-1:0];
        if (cmd.samp_rd)
        begin
            raddr = samp_idx_reg;
        end
        else if (cmd.move_rd)
        begin
            raddr = last_idx[IDX_W-1:0];
        end
    end

    always_comb
    begin
        we    = cmd.append || cmd.move_wr;
        waddr = cmp_idx_reg;
        wdata = rd_data_reg;
        if (cmd.append)
        begin
            waddr = count_reg[IDX_W-1:0];
            wdata = value_reg;
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        if (cmd.load)
        begin
            scan_idx_next  = '0;
            cmp_valid_next = 1'b0;
        end
        else if (cmd.scan && !hit)
        begin
            // the compare follows the read in the next cycle, on the registered read data
            cmp_valid_next = scan_more;
            if (scan_more)
            begin
                cmp_idx_next  = scan_idx_reg[IDX_W-1:0];
                scan_idx_next = scan_idx_reg + CNT_W'(1);
            end
        end
        if (cmd.append)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.move_wr)
        begin
            count_next = last_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg <= req_value;
            draw_reg  <= req_draw;
        end
        if (cmd.samp_mul)
        begin
            samp_idx_reg <= IDX_W'(prod >> DRAW_BITS);
        end
        if (cmd.finish)
        begin
            status_out_reg <= cmd.status;
            sample_out_reg <= cmd.take_sample ? rd_data_reg : '0;
            size_out_reg   <= rstab_pkg::SIZE_W'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_idx_reg   <= '0;
        end
        else
        begin
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_idx_reg   <= cmp_idx_next;
        end
    end

    assign rsp_status = status_out_reg;
    assign rsp_sample = sample_out_reg;
    assign rsp_size   = size_out_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |-> (count_reg < CNT_W'(CAPACITY)))
        else $error("append into a full store");

    a_move_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.move_wr |-> $past(cmd.move_rd) && (count_reg != '0))
        else $error("move without a preceding last-entry read");

    a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan && cmp_valid_reg |-> (CNT_W'(cmp_idx_reg) < count_reg))
        else $error("compare slot outside occupied entries");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.append && !cmd.move_wr |=> $stable(count_reg))
        else $error("count changed without append or move");
`endif

endmodule
